/* hdl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg: shared types and constants of the Huffman code bit packer
// Holds field widths, item mode codes and the default table dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

	// Default table dimensions
	localparam int MAX_CODE_LEN_DEF  = 32;
	localparam int ALPHABET_SIZE_DEF = 256;

	// Field widths of one item and one result
	localparam int MODE_W   = 2;
	localparam int SYMBOL_W = 8;
	localparam int CODE_W   = 32;
	localparam int LEN_IN_W = 6;
	localparam int BYTE_W   = 8;

	// Bit accumulator: pending bits never exceed WORD_LIMIT after an item
	localparam int WORD_LIMIT = 32;
	localparam int ACC_W      = 64;
	localparam int PEND_W     = 7;

	// Item mode codes
	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

endpackage

`default_nettype wire

/* hdl/hcbp_if.sv */
// ----------------------------------------------------------------------------
// hcbp_if: channel interfaces of the Huffman code bit packer
// One valid/ready channel for incoming items and one for packed bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_item_if;
	logic                               valid;
	logic                               ready;
	logic [hcbp_pkg::MODE_W-1:0]        mode;
	logic [hcbp_pkg::SYMBOL_W-1:0]      symbol;
	logic [hcbp_pkg::CODE_W-1:0]        code_bits;
	logic [hcbp_pkg::LEN_IN_W-1:0]      code_len;

	modport source (output valid, mode, symbol, code_bits, code_len, input ready);
	modport sink   (input valid, mode, symbol, code_bits, code_len, output ready);
endinterface

interface hcbp_byte_if;
	logic                               valid;
	logic                               ready;
	logic [hcbp_pkg::BYTE_W-1:0]        out_byte;
	logic                               last;

	modport source (output valid, out_byte, last, input ready);
	modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

/* hdl/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer: table-driven Huffman code bit packer
// Looks up code words per byte value and packs them MSB-first into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: mode selects load (write one table entry), encode (append
//   the code of symbol) or flush (drain pending bits, zero-pad last byte).
//   byte channel: packed bytes, last marks the final byte of one item.
//   An encode reads the table entry, appends the code to the accumulator
//   and then emits 0 to 4 bytes; a flush emits at most 4 bytes. The emit
//   loop shares one shifter that pulls each byte out of the 64-bit
//   accumulator; the table is a RAM with registered read.
//   item.ready is high only while the sequencer is idle; the output register
//   may still hold the last byte then, so a new item is taken while the
//   receiver has not taken it yet.
//   When the receiver stalls, the emit loop holds until the output register
//   frees up. Reset clears the valid marks, the accumulator and the
//   sequencer; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer #(
	parameter int MAX_CODE_LEN  = hcbp_pkg::MAX_CODE_LEN_DEF,
	parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	hcbp_item_if.sink   item,
	hcbp_byte_if.source result
);

	localparam int ADDR_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
	localparam int ENTRY_W = LEN_W + MAX_CODE_LEN;
	localparam int EXT_W   = hcbp_pkg::ACC_W + hcbp_pkg::BYTE_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_APPEND = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t                          st_q;
	logic                            flush_q;
	logic [ALPHABET_SIZE-1:0]        valid_q;
	logic [hcbp_pkg::ACC_W-1:0]      acc_q;
	logic [hcbp_pkg::PEND_W-1:0]     pend_q;
	logic                            res_valid_q;
	logic [hcbp_pkg::BYTE_W-1:0]     res_byte_q;
	logic                            res_last_q;

	logic                            item_fire;
	logic                            sym_ok;
	logic [ADDR_W-1:0]               sym_idx;
	logic [LEN_W-1:0]                len_sat;
	logic [hcbp_pkg::CODE_W:0]       len_mask;
	logic [hcbp_pkg::CODE_W:0]       code_masked;
	logic                            tbl_we;
	logic                            tbl_re;
	logic [ENTRY_W-1:0]              tbl_wdata;
	logic [ENTRY_W-1:0]              tbl_rdata;
	logic [LEN_W-1:0]                rd_len;
	logic [MAX_CODE_LEN-1:0]         rd_code;
	logic [hcbp_pkg::PEND_W-1:0]     pend_sum;
	logic [EXT_W-1:0]                ext;
	logic                            out_free;
	logic                            emit_fire;
	logic                            emit_last;

	// Decode the incoming beat
	assign item.ready = (st_q == ST_IDLE);
	assign item_fire  = item.valid && item.ready;
	assign sym_ok     = ({1'b0, item.symbol} < (hcbp_pkg::SYMBOL_W+1)'(ALPHABET_SIZE));
	assign sym_idx    = ADDR_W'(item.symbol);

	// Saturate the length and mask code bits above it
	always_comb begin
		if (item.code_len > hcbp_pkg::LEN_IN_W'(MAX_CODE_LEN)) begin
			len_sat = LEN_W'(MAX_CODE_LEN);
		end else begin
			len_sat = LEN_W'(item.code_len);
		end
	end
	assign len_mask    = ((hcbp_pkg::CODE_W+1)'(1) << len_sat) - (hcbp_pkg::CODE_W+1)'(1);
	assign code_masked = {1'b0, item.code_bits} & len_mask;
	assign tbl_wdata   = {len_sat, code_masked[MAX_CODE_LEN-1:0]};

	assign tbl_we = item_fire && (item.mode == hcbp_pkg::MODE_LOAD) && sym_ok;
	assign tbl_re = item_fire && (item.mode == hcbp_pkg::MODE_ENCODE) && sym_ok &&
		valid_q[sym_idx];

	hcbp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ALPHABET_SIZE)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(sym_idx),
		.wdata(tbl_wdata),
		.re   (tbl_re),
		.raddr(sym_idx),
		.rdata(tbl_rdata)
	);

	assign rd_len   = tbl_rdata[ENTRY_W-1:MAX_CODE_LEN];
	assign rd_code  = tbl_rdata[MAX_CODE_LEN-1:0];
	assign pend_sum = pend_q + hcbp_pkg::PEND_W'(rd_len);

	// Shared byte extractor: bits just below the pending count, zero-padded
	assign ext       = {acc_q, hcbp_pkg::BYTE_W'(0)} >> pend_q;
	assign out_free  = !res_valid_q || result.ready;
	assign emit_fire = (st_q == ST_EMIT) && out_free;

	always_comb begin
		if (flush_q) begin
			emit_last = (pend_q <= hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_W));
		end else begin
			emit_last = (pend_q <= hcbp_pkg::PEND_W'(hcbp_pkg::WORD_LIMIT + hcbp_pkg::BYTE_W));
		end
	end

	// Mark loaded entries valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (tbl_we) begin
			valid_q[sym_idx] <= 1'b1;
		end
	end

	// Sequencer and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			flush_q <= 1'b0;
			acc_q   <= '0;
			pend_q  <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (tbl_re) begin
						flush_q <= 1'b0;
						st_q    <= ST_APPEND;
					end else if (item_fire && (item.mode == hcbp_pkg::MODE_FLUSH)) begin
						flush_q <= 1'b1;
						if (pend_q != '0) begin
							st_q <= ST_EMIT;
						end else begin
							acc_q <= '0;
						end
					end
				end
				ST_APPEND: begin
					acc_q  <= (acc_q << rd_len) | hcbp_pkg::ACC_W'(rd_code);
					pend_q <= pend_sum;
					if (pend_sum > hcbp_pkg::PEND_W'(hcbp_pkg::WORD_LIMIT)) begin
						st_q <= ST_EMIT;
					end else begin
						st_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						if (flush_q && emit_last) begin
							pend_q <= '0;
							acc_q  <= '0;
						end else begin
							pend_q <= pend_q - hcbp_pkg::PEND_W'(hcbp_pkg::BYTE_W);
						end
						if (emit_last) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: load a byte, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			res_byte_q <= ext[hcbp_pkg::BYTE_W-1:0];
			res_last_q <= emit_last;
		end
	end

	assign result.valid    = res_valid_q;
	assign result.out_byte = res_byte_q;
	assign result.last     = res_last_q;

	// Checks
	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q))
		else $error("sequencer state is not one-hot");

	a_idle_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> (pend_q <= hcbp_pkg::PEND_W'(hcbp_pkg::WORD_LIMIT)))
		else $error("more than a word pending while idle");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT) |-> (pend_q != '0))
		else $error("emit loop running with nothing pending");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && emit_last && flush_q) |=> (pend_q == '0 && st_q == ST_IDLE))
		else $error("flush did not empty the accumulator");

endmodule

`default_nettype wire

/* tb/tb_huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer: self-checking testbench of the code bit packer
// Drives load, encode, flush and unused-mode items with random idle cycles on
// both channels, predicts the packed byte stream from its own copy of the
// code table and bit accumulator, and compares every byte beat in order.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer;
	timeunit 1ns;
	timeprecision 1ps;

	// Field widths and codes taken from the package
	localparam int MODE_W            = hcbp_pkg::MODE_W;
	localparam int SYMBOL_W          = hcbp_pkg::SYMBOL_W;
	localparam int CODE_W            = hcbp_pkg::CODE_W;
	localparam int LEN_IN_W          = hcbp_pkg::LEN_IN_W;
	localparam int BYTE_W            = hcbp_pkg::BYTE_W;
	localparam int ACC_W             = hcbp_pkg::ACC_W;
	localparam int WORD_LIMIT        = hcbp_pkg::WORD_LIMIT;
	localparam int MAX_CODE_LEN_DEF  = hcbp_pkg::MAX_CODE_LEN_DEF;
	localparam int ALPHABET_SIZE_DEF = hcbp_pkg::ALPHABET_SIZE_DEF;

	localparam logic [MODE_W-1:0] MODE_LOAD   = hcbp_pkg::MODE_LOAD;
	localparam logic [MODE_W-1:0] MODE_ENCODE = hcbp_pkg::MODE_ENCODE;
	localparam logic [MODE_W-1:0] MODE_FLUSH  = hcbp_pkg::MODE_FLUSH;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int MAX_WAIT    = 9;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 20000;
	localparam int SETTLE      = 50;
	localparam int TIMEOUT_NS  = 2_000_000;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [SYMBOL_W-1:0] symbol;
		logic [CODE_W-1:0]   code_bits;
		logic [LEN_IN_W-1:0] code_len;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} packed_byte_t;

	logic clk;
	logic arst_n;

	hcbp_item_if item_ch ();
	hcbp_byte_if byte_ch ();

	huffman_code_bit_packer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (byte_ch)
	);

	// Predictor state: code table, valid marks and bit accumulator
	logic [CODE_W-1:0]   code_word_tab [ALPHABET_SIZE_DEF];
	logic [LEN_IN_W-1:0] code_len_tab  [ALPHABET_SIZE_DEF];
	logic                code_known    [ALPHABET_SIZE_DEF];
	logic [ACC_W-1:0]    bit_acc;
	int                  bit_cnt;
	logic [SYMBOL_W-1:0] loaded_syms [$];

	packed_byte_t expected_bytes [$];
	int           err_cnt;
	bit           idle_on;
	int           hold_left;
	int           beat_wait;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop
	initial begin
		#(TIMEOUT_NS);
		$display("** huffman_code_bit_packer: FAILED **");
		$finish;
	end

	// Work out the bytes one item releases and queue them
	function automatic void predict_packed_bytes(input item_t it);
		logic [LEN_IN_W-1:0] len;
		logic [ACC_W-1:0]    mask;
		logic [ACC_W-1:0]    shifted;
		packed_byte_t        produced [$];
		case (it.mode)
		MODE_LOAD: begin
			len = (it.code_len > MAX_CODE_LEN_DEF) ? LEN_IN_W'(MAX_CODE_LEN_DEF) : it.code_len;
			mask = (64'd1 << len) - 64'd1;
			code_word_tab[it.symbol] = it.code_bits & mask[CODE_W-1:0];
			code_len_tab[it.symbol] = len;
			if (!code_known[it.symbol])
				loaded_syms.push_back(it.symbol);
			code_known[it.symbol] = 1'b1;
		end
		MODE_ENCODE: begin
			if (code_known[it.symbol]) begin
				bit_acc = (bit_acc << code_len_tab[it.symbol]) |
					ACC_W'(code_word_tab[it.symbol]);
				bit_cnt += code_len_tab[it.symbol];
				// Emit while more than one word is pending
				while (bit_cnt > WORD_LIMIT) begin
					shifted = bit_acc >> (bit_cnt - BYTE_W);
					produced.push_back('{shifted[BYTE_W-1:0], 1'b0});
					bit_cnt -= BYTE_W;
				end
			end
		end
		MODE_FLUSH: begin
			// Drain everything, zero-pad the tail byte
			while (bit_cnt > 0) begin
				if (bit_cnt >= BYTE_W) begin
					shifted = bit_acc >> (bit_cnt - BYTE_W);
					bit_cnt -= BYTE_W;
				end else begin
					shifted = bit_acc << (BYTE_W - bit_cnt);
					bit_cnt = 0;
				end
				produced.push_back('{shifted[BYTE_W-1:0], 1'b0});
			end
			bit_acc = '0;
		end
		default: ;
		endcase
		if (produced.size() > 0)
			produced[$].last = 1'b1;
		foreach (produced[k])
			expected_bytes.push_back(produced[k]);
	endfunction

	function automatic item_t make_item(input logic [MODE_W-1:0] mode,
			input logic [SYMBOL_W-1:0] sym, input logic [CODE_W-1:0] bits,
			input logic [LEN_IN_W-1:0] len);
		return '{mode, sym, bits, len};
	endfunction

	// Mostly short codes, some long ones, some beyond the maximum
	function automatic logic [LEN_IN_W-1:0] rand_code_len();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r <= 12)
			return LEN_IN_W'($urandom_range(1, 12));
		if (r <= 17)
			return LEN_IN_W'($urandom_range(13, 32));
		return LEN_IN_W'($urandom_range(33, 63));
	endfunction

	// Well-formed traffic: loads, encodes of loaded bytes, flushes, some noise
	function automatic item_t rand_item();
		item_t it;
		int    r;
		it = make_item(MODE_LOAD, SYMBOL_W'($urandom_range(0, 255)), $urandom,
			rand_code_len());
		r = $urandom_range(0, 99);
		if (loaded_syms.size() < 8 || r < 15) begin
			it.mode = MODE_LOAD;
		end else if (r < 82) begin
			it.mode = MODE_ENCODE;
			it.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
		end else if (r < 93) begin
			it.mode = MODE_FLUSH;
		end else begin
			it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input item_t it);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid     = 1'b1;
		item_ch.mode      = it.mode;
		item_ch.symbol    = it.symbol;
		item_ch.code_bits = it.code_bits;
		item_ch.code_len  = it.code_len;
		do @(posedge clk); while (!item_ch.ready);
		predict_packed_bytes(it);
		@(negedge clk);
	endtask

	task automatic stop_items();
		item_ch.valid = 1'b0;
	endtask

	task automatic test_empty_flush_and_unused();
		send_item(make_item(MODE_FLUSH, 8'h00, 32'h0, 6'd0));
		send_item(make_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
		stop_items();
	endtask

	task automatic test_directed_codes();
		// Extremes of the table fields
		send_item(make_item(MODE_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
		send_item(make_item(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0));
		send_item(make_item(MODE_LOAD, 8'h80, 32'hDEAD_BEEF, 6'd63));
		send_item(make_item(MODE_LOAD, 8'h55, 32'hFFFF_FFFF, 6'd5));
		send_item(make_item(MODE_LOAD, 8'hAA, 32'h0000_0000, 6'd1));
		send_item(make_item(MODE_LOAD, 8'h0F, 32'h0000_1234, 6'd13));
		// Fill to one word, then overflow into four bytes
		send_item(make_item(MODE_ENCODE, 8'hFF, 32'h0, 6'd0));
		send_item(make_item(MODE_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd63));
		send_item(make_item(MODE_ENCODE, 8'h00, 32'h0, 6'd0));
		send_item(make_item(MODE_ENCODE, 8'h55, 32'h0, 6'd0));
		send_item(make_item(MODE_ENCODE, 8'hAA, 32'h0, 6'd0));
		send_item(make_item(MODE_ENCODE, 8'h80, 32'h0, 6'd0));
		send_item(make_item(MODE_ENCODE, 8'h0F, 32'h0, 6'd0));
		// Partial tail byte, then nothing left
		send_item(make_item(MODE_FLUSH, 8'h00, 32'h0, 6'd0));
		send_item(make_item(MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63));
		// Reload one entry and use the new code
		send_item(make_item(MODE_LOAD, 8'h55, 32'h0000_0000, 6'd7));
		send_item(make_item(MODE_ENCODE, 8'h55, 32'h0, 6'd0));
		send_item(make_item(MODE_FLUSH, 8'h00, 32'h0, 6'd0));
		stop_items();
	endtask

	task automatic test_random_stream(input int count);
		for (int k = 0; k < count; k++)
			send_item(rand_item());
		stop_items();
	endtask

	task automatic test_output_backpressure();
		logic [SYMBOL_W-1:0] long_syms [3];
		long_syms = '{8'h11, 8'h22, 8'h33};
		send_item(make_item(MODE_LOAD, long_syms[0], $urandom, 6'd24));
		send_item(make_item(MODE_LOAD, long_syms[1], $urandom, 6'd30));
		send_item(make_item(MODE_LOAD, long_syms[2], $urandom, 6'd32));
		stop_items();
		// Hold the byte side off while encodes keep coming
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		@(negedge clk);
		for (int k = 0; k < 30; k++)
			send_item(make_item(MODE_ENCODE, long_syms[$urandom_range(0, 2)],
				$urandom, rand_code_len()));
		send_item(make_item(MODE_FLUSH, 8'h00, 32'h0, 6'd0));
		stop_items();
	endtask

	task automatic test_no_idle(input int count);
		idle_on = 1'b0;
		for (int k = 0; k < count; k++)
			send_item(rand_item());
		send_item(make_item(MODE_FLUSH, 8'h00, 32'h0, 6'd0));
		stop_items();
		idle_on = 1'b1;
	endtask

	// Byte receiver: long hold-off first, then per-beat random wait
	initial begin : byte_receiver
		byte_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				byte_ch.ready = 1'b0;
				hold_left--;
			end else if (beat_wait > 0) begin
				byte_ch.ready = 1'b0;
				beat_wait--;
			end else begin
				byte_ch.ready = 1'b1;
			end
		end
	end

	// Compare every accepted byte beat with the oldest expectation
	initial begin : byte_checker
		packed_byte_t want;
		forever begin
			@(posedge clk);
			if (arst_n && byte_ch.valid && byte_ch.ready) begin
				if (expected_bytes.size() == 0) begin
					if (err_cnt < 10)
						$display("unexpected beat at %0t: out_byte %02h last %0b",
							$time, byte_ch.out_byte, byte_ch.last);
					err_cnt++;
				end else begin
					want = expected_bytes.pop_front();
					if (byte_ch.out_byte !== want.data || byte_ch.last !== want.last) begin
						if (err_cnt < 10)
							$display({"mismatch at %0t: out_byte %02h last %0b, ",
								"expected %02h last %0b"},
								$time, byte_ch.out_byte, byte_ch.last, want.data, want.last);
						err_cnt++;
					end
				end
				beat_wait = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			end
		end
	end

	initial begin
		item_ch.valid     = 1'b0;
		item_ch.mode      = MODE_LOAD;
		item_ch.symbol    = '0;
		item_ch.code_bits = '0;
		item_ch.code_len  = '0;
		arst_n    = 1'b0;
		err_cnt   = 0;
		idle_on   = 1'b1;
		hold_left = 0;
		beat_wait = 0;
		bit_acc   = '0;
		bit_cnt   = 0;
		foreach (code_known[k]) begin
			code_known[k]    = 1'b0;
			code_word_tab[k] = '0;
			code_len_tab[k]  = '0;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_flush_and_unused();
		test_directed_codes();
		test_random_stream(180);
		test_output_backpressure();
		test_no_idle(40);

		// Let the last bytes drain, then watch for stray beats
		for (int k = 0; k < DRAIN_LIMIT && expected_bytes.size() != 0; k++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		err_cnt += expected_bytes.size();

		if (err_cnt == 0)
			$display("** huffman_code_bit_packer: PASSED **");
		else
			$display("** huffman_code_bit_packer: FAILED **");
		$finish;
	end

endmodule

/* files.f */
hdl/hcbp_pkg.sv
hdl/hcbp_if.sv
hdl/hcbp_ram.sv
hdl/huffman_code_bit_packer.sv
tb/tb_huffman_code_bit_packer.sv
